### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/gsp_pkg.sv
// ---------------------------------------------------------------------------
// gsp_pkg
// Types and constants shared by the gamepad serial poller.
// ---------------------------------------------------------------------------
package gsp_pkg;

  // Poll sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LATCH_HIGH = 3'd1,
    PH_LATCH_LOW  = 3'd2,
    PH_CLOCK_HIGH = 3'd3,
    PH_CLOCK_LOW  = 3'd4
  } phase_t;

  localparam int BIT_IDX_W       = 6;
  localparam int KEYPAD_BITS     = 16;
  localparam int KEYPAD_SKIP_POS = 14;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_LATCH_HIGH = 3'd0;
  localparam logic [2:0] REG_LATCH_LOW  = 3'd1;
  localparam logic [2:0] REG_CLOCK_HIGH = 3'd2;
  localparam logic [2:0] REG_CLOCK_LOW  = 3'd3;
  localparam logic [2:0] REG_PLAYER     = 3'd4;

  localparam logic [2:0] PLAYER_MIN = 3'd1;
  localparam logic [2:0] PLAYER_MAX = 3'd4;

  // Configuration register file
  typedef struct packed {
    logic [7:0] latch_high_ticks;
    logic [7:0] latch_low_ticks;
    logic [7:0] clock_high_ticks;
    logic [7:0] clock_low_ticks;
    logic [2:0] player_number;
  } gsp_cfg_t;

  // Poll sequencer state
  typedef struct packed {
    phase_t                 phase;
    logic [7:0]             tick_count;
    logic [BIT_IDX_W-1:0]   bit_index;
    logic [15:0]            button_reg;
    logic [KEYPAD_BITS-1:0] keypad_reg;
    logic                   present_flag;
    logic                   connected_flag;
  } gsp_state_t;

endpackage

### hw/rtl/gsp_step.sv
// ---------------------------------------------------------------------------
// gsp_step
// One tick of the poll sequencer: next state and completion flag.
// ---------------------------------------------------------------------------
module gsp_step
  import gsp_pkg::*;
#(
  parameter int BUTTON_BITS = 16,
  parameter int TOTAL_BITS  = 32,
  parameter int DETECT_BIT  = 13
) (
  input  gsp_state_t st,
  input  gsp_cfg_t   cfg,
  input  logic       start_poll,
  input  logic       data_line,
  input  logic       keypad_line,
  output gsp_state_t st_next,
  output logic       done
);

  localparam logic [16:0] ONES_WIDE = (17'd1 << BUTTON_BITS) - 17'd1;
  localparam logic [15:0] ALL_ONES  = ONES_WIDE[15:0];

  // Store one sampled bit at shift position b
  function automatic gsp_state_t sample_bit(gsp_state_t s, logic [BIT_IDX_W-1:0] b,
                                            logic dl, logic kl);
    gsp_state_t r;
    logic [BIT_IDX_W-1:0] k;
    r = s;
    k = b - BIT_IDX_W'(BUTTON_BITS);
    if (b < BIT_IDX_W'(BUTTON_BITS)) begin
      if (dl) begin
        r.button_reg[b[3:0]] = 1'b1;
        if (b == BIT_IDX_W'(DETECT_BIT)) r.present_flag = 1'b1;
      end
    end else if (kl && k < BIT_IDX_W'(KEYPAD_BITS) && k != BIT_IDX_W'(KEYPAD_SKIP_POS)) begin
      r.keypad_reg[k[3:0]] = 1'b1;
    end
    return r;
  endfunction

  logic [7:0]           len;
  logic [7:0]           tick_inc;
  logic                 over;
  logic [BIT_IDX_W:0]   nxt;
  logic                 more;
  logic                 data_low;
  logic                 key_low;

  assign data_low = ~data_line;
  assign key_low  = ~keypad_line;
  assign tick_inc = st.tick_count + 8'd1;
  assign nxt      = {1'b0, st.bit_index} + (BIT_IDX_W+1)'(1);
  assign more     = (nxt < (BIT_IDX_W+1)'(BUTTON_BITS)) ||
                    (st.present_flag && nxt < (BIT_IDX_W+1)'(TOTAL_BITS));

  // Length of the current phase; zero counts as one
  always_comb begin
    unique case (st.phase)
      PH_LATCH_HIGH: len = cfg.latch_high_ticks;
      PH_LATCH_LOW:  len = cfg.latch_low_ticks;
      PH_CLOCK_HIGH: len = cfg.clock_high_ticks;
      PH_CLOCK_LOW:  len = cfg.clock_low_ticks;
      default:       len = 8'd1;
    endcase
    if (len == 8'd0) len = 8'd1;
  end

  assign over = (tick_inc >= len);

  // Sequencer next state
  always_comb begin
    st_next = st;
    done    = 1'b0;
    unique case (st.phase)
      PH_IDLE: begin
        if (start_poll) begin
          st_next.button_reg   = '0;
          st_next.keypad_reg   = '0;
          st_next.present_flag = 1'b0;
          st_next.bit_index    = '0;
          st_next.tick_count   = '0;
          st_next.phase        = PH_LATCH_HIGH;
        end
      end
      PH_LATCH_HIGH: begin
        st_next.tick_count = over ? 8'd0 : tick_inc;
        if (over) st_next.phase = PH_LATCH_LOW;
      end
      PH_LATCH_LOW: begin
        st_next.tick_count = over ? 8'd0 : tick_inc;
        if (over) begin
          st_next           = sample_bit(st_next, '0, data_low, key_low);
          st_next.bit_index = '0;
          st_next.phase     = PH_CLOCK_HIGH;
        end
      end
      PH_CLOCK_HIGH: begin
        st_next.tick_count = over ? 8'd0 : tick_inc;
        if (over) st_next.phase = PH_CLOCK_LOW;
      end
      PH_CLOCK_LOW: begin
        st_next.tick_count = over ? 8'd0 : tick_inc;
        if (over) begin
          if (more) begin
            st_next           = sample_bit(st_next, nxt[BIT_IDX_W-1:0], data_low, key_low);
            st_next.bit_index = nxt[BIT_IDX_W-1:0];
            st_next.phase     = PH_CLOCK_HIGH;
          end else begin
            st_next.connected_flag = ((st.button_reg & ALL_ONES) != ALL_ONES) ||
                                     st.present_flag;
            st_next.bit_index      = '0;
            st_next.phase          = PH_IDLE;
            done                   = 1'b1;
          end
        end
      end
      default: begin
        st_next.phase      = PH_IDLE;
        st_next.tick_count = '0;
      end
    endcase
  end

endmodule

### hw/rtl/gamepad_serial_poller.sv
// ---------------------------------------------------------------------------
// gamepad_serial_poller
// Latch/clock shift-register gamepad reader with keypad extension.
// ---------------------------------------------------------------------------
// Each input word is one tick of the timing base; every accepted word yields
// exactly one result word, which appears in the output register in the cycle
// after acceptance. The block takes one word per cycle as long as the result
// side keeps up: the single output register is the only stage, and s_tready
// stays high while it is empty or being drained. A poll spans
// latch_high + latch_low + n*(clock_high + clock_low) ticks for n bits
// (16, or 32 with the keypad extension present).
// ---------------------------------------------------------------------------
module gamepad_serial_poller
  import gsp_pkg::*;
#(
  parameter int BUTTON_BITS = 16,
  parameter int TOTAL_BITS  = 32,
  parameter int DETECT_BIT  = 13
) (
  input  logic        clk,
  input  logic        rst,
  // tick stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] start_poll, [1] data_line, [2] keypad_line
  // result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [0] latch_out, [1] clock_out, [2] poll_done,
                                 // [18:3] buttons, [34:19] keypad_keys,
                                 // [35] keypad_present, [36] connected,
                                 // [39:37] player, [40] busy_res
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  gsp_cfg_t   cfg;
  gsp_state_t st;
  gsp_state_t st_next;
  logic       done;
  logic       in_acc;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic [40:0] res_next;
  logic [40:0] res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.latch_high_ticks <= 8'd192;
      cfg.latch_low_ticks  <= 8'd72;
      cfg.clock_high_ticks <= 8'd96;
      cfg.clock_low_ticks  <= 8'd72;
      cfg.player_number    <= PLAYER_MIN;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LATCH_HIGH: cfg.latch_high_ticks <= pwdata[7:0];
        REG_LATCH_LOW:  cfg.latch_low_ticks  <= pwdata[7:0];
        REG_CLOCK_HIGH: cfg.clock_high_ticks <= pwdata[7:0];
        REG_CLOCK_LOW:  cfg.clock_low_ticks  <= pwdata[7:0];
        REG_PLAYER: begin
          if (pwdata[2:0] >= PLAYER_MIN && pwdata[2:0] <= PLAYER_MAX)
            cfg.player_number <= pwdata[2:0];
        end
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_LATCH_HIGH: prdata = {24'd0, cfg.latch_high_ticks};
      REG_LATCH_LOW:  prdata = {24'd0, cfg.latch_low_ticks};
      REG_CLOCK_HIGH: prdata = {24'd0, cfg.clock_high_ticks};
      REG_CLOCK_LOW:  prdata = {24'd0, cfg.clock_low_ticks};
      REG_PLAYER:     prdata = {29'd0, cfg.player_number};
      default:        prdata = '0;
    endcase
  end

  // Sequencer step logic
  gsp_step #(
    .BUTTON_BITS (BUTTON_BITS),
    .TOTAL_BITS  (TOTAL_BITS),
    .DETECT_BIT  (DETECT_BIT)
  ) u_step (
    .st          (st),
    .cfg         (cfg),
    .start_poll  (s_tdata[0]),
    .data_line   (s_tdata[1]),
    .keypad_line (s_tdata[2]),
    .st_next     (st_next),
    .done        (done)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_IDLE;
      st.tick_count     <= '0;
      st.bit_index      <= '0;
      st.button_reg     <= '0;
      st.keypad_reg     <= '0;
      st.present_flag   <= 1'b0;
      st.connected_flag <= 1'b0;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // Result word from the post-tick state
  assign res_next = {
    st_next.phase != PH_IDLE,
    cfg.player_number,
    st_next.connected_flag,
    st_next.present_flag,
    st_next.keypad_reg,
    st_next.button_reg,
    done,
    st_next.phase == PH_CLOCK_HIGH,
    st_next.phase == PH_LATCH_HIGH
  };

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res <= res_next;
  end

  assign m_tdata = {7'd0, res};

  // Checks
  `ASSERT_NEXT(a_poll_start, clk, rst,
    in_acc && st.phase == PH_IDLE && s_tdata[0], st.phase == PH_LATCH_HIGH)
  `ASSERT_IMPLY(a_idle_clean, clk, rst,
    st.phase == PH_IDLE, st.tick_count == 8'd0 && st.bit_index == '0)
  `ASSERT_IMPLY(a_done_not_busy, clk, rst,
    m_tvalid && res[2], !res[40] && !res[0] && !res[1])
  `ASSERT_IMPLY(a_pins_busy, clk, rst,
    m_tvalid && (res[0] || res[1]), res[40])

endmodule

### sim/gamepad_serial_poller_tb.sv
// ----------------------------------------------------------------------------
// gamepad_serial_poller_tb
// Self-checking bench for the latch/clock gamepad poller.
// ----------------------------------------------------------------------------
// Every tick word sent into the poller is run through a shadow copy of the
// poll sequencer, which queues the result word that tick must produce. Result
// words are compared field by field as they leave the block. Directed polls
// cover the corner cases first. Random polls follow, under changing timing
// and player registers and under three idling patterns. One long receiver
// hold-off backs up the input side, and one poll runs with the latch-high
// count at its maximum.
// ----------------------------------------------------------------------------
module gamepad_serial_poller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsp_pkg::*;

  // Result word layout, lowest bit last
  typedef struct packed {
    logic [6:0]  pad;
    logic        busy;
    logic [2:0]  player;
    logic        connected;
    logic        present;
    logic [15:0] keys;
    logic [15:0] buttons;
    logic        done;
    logic        clock;
    logic        latch;
  } poll_result_t;

  // Shadow of the poll sequencer plus the queue of result words still due
  class poll_shadow;
    localparam int N_BUTTONS = 16;
    localparam int N_TOTAL = 32;
    localparam int DETECT_POS = 13;
    localparam bit [15:0] ALL_PRESSED = 16'((32'd1 << N_BUTTONS) - 1);

    bit [7:0]     latch_hi_len, latch_lo_len, clk_hi_len, clk_lo_len;
    bit [2:0]     player_no;
    phase_t       phase;
    bit [7:0]     tick_cnt;
    bit [5:0]     bit_idx;
    bit [15:0]    buttons, keys;
    bit           present, connected;
    poll_result_t due_results[$];
    int           errors, words_in, words_out, polls_done, keypad_polls, settings;

    function new();
      latch_hi_len = 8'd192;
      latch_lo_len = 8'd72;
      clk_hi_len   = 8'd96;
      clk_lo_len   = 8'd72;
      player_no    = 3'd1;
      phase        = PH_IDLE;
      tick_cnt     = '0;
      bit_idx      = '0;
      buttons      = '0;
      keys         = '0;
      present      = 1'b0;
      connected    = 1'b0;
    endfunction

    function void write_reg(int idx, bit [31:0] value);
      case (idx)
        REG_LATCH_HIGH: latch_hi_len = value[7:0];
        REG_LATCH_LOW:  latch_lo_len = value[7:0];
        REG_CLOCK_HIGH: clk_hi_len = value[7:0];
        REG_CLOCK_LOW:  clk_lo_len = value[7:0];
        REG_PLAYER: begin
          // out-of-range player numbers are dropped
          if (value[2:0] >= PLAYER_MIN && value[2:0] <= PLAYER_MAX) player_no = value[2:0];
        end
        default: ;
      endcase
      settings++;
    endfunction

    function bit [31:0] read_reg(int idx);
      case (idx)
        REG_LATCH_HIGH: return {24'd0, latch_hi_len};
        REG_LATCH_LOW:  return {24'd0, latch_lo_len};
        REG_CLOCK_HIGH: return {24'd0, clk_hi_len};
        REG_CLOCK_LOW:  return {24'd0, clk_lo_len};
        default:        return {29'd0, player_no};
      endcase
    endfunction

    function bit idle();
      return phase == PH_IDLE;
    endfunction

    // Shift position sampled if the current phase ends on the next tick
    function int next_sample_pos();
      if (phase == PH_CLOCK_LOW) return bit_idx + 1;
      return 0;
    endfunction

    // Counts one tick; a length of zero behaves as one
    function bit phase_done(bit [7:0] len);
      bit [7:0] span;
      span = (len == 8'd0) ? 8'd1 : len;
      tick_cnt++;
      if (tick_cnt >= span) begin
        tick_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_sample(bit data_low, bit key_low);
      int k;
      if (bit_idx < N_BUTTONS) begin
        if (data_low) begin
          buttons[bit_idx] = 1'b1;
          if (bit_idx == DETECT_POS) present = 1'b1;
        end
      end else begin
        k = bit_idx - N_BUTTONS;
        if (key_low && k < KEYPAD_BITS && k != KEYPAD_SKIP_POS) keys[k] = 1'b1;
      end
    endfunction

    // One accepted tick word: advance the sequencer, queue the result word
    function void take_tick(logic [7:0] w);
      bit           start, data_low, key_low, done, more;
      int           nxt;
      poll_result_t r;
      start    = w[0];
      data_low = !w[1];
      key_low  = !w[2];
      done     = 1'b0;
      words_in++;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            buttons  = '0;
            keys     = '0;
            present  = 1'b0;
            bit_idx  = '0;
            tick_cnt = '0;
            phase    = PH_LATCH_HIGH;
          end
        end
        PH_LATCH_HIGH: begin
          if (phase_done(latch_hi_len)) phase = PH_LATCH_LOW;
        end
        PH_LATCH_LOW: begin
          if (phase_done(latch_lo_len)) begin
            bit_idx = '0;
            take_sample(data_low, key_low);
            phase = PH_CLOCK_HIGH;
          end
        end
        PH_CLOCK_HIGH: begin
          if (phase_done(clk_hi_len)) phase = PH_CLOCK_LOW;
        end
        PH_CLOCK_LOW: begin
          if (phase_done(clk_lo_len)) begin
            nxt  = bit_idx + 1;
            more = (nxt < N_BUTTONS) || (present && nxt < N_TOTAL);
            if (more) begin
              bit_idx = nxt[5:0];
              take_sample(data_low, key_low);
              phase = PH_CLOCK_HIGH;
            end else begin
              connected = (buttons != ALL_PRESSED) || present;
              bit_idx   = '0;
              phase     = PH_IDLE;
              done      = 1'b1;
              polls_done++;
              if (present) keypad_polls++;
            end
          end
        end
        default: begin
          phase    = PH_IDLE;
          tick_cnt = '0;
        end
      endcase
      r           = '0;
      r.latch     = (phase == PH_LATCH_HIGH);
      r.clock     = (phase == PH_CLOCK_HIGH);
      r.done      = done;
      r.buttons   = buttons;
      r.keys      = keys;
      r.present   = present;
      r.connected = connected;
      r.player    = player_no;
      r.busy      = (phase != PH_IDLE);
      due_results.push_back(r);
    endfunction

    function void flag_mismatch(string what, logic [47:0] exp, logic [47:0] got);
      errors++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, exp, got);
    endfunction

    function void match_result(logic [47:0] data);
      poll_result_t got, exp;
      got = data;
      words_out++;
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected result word", '0, data);
        return;
      end
      exp = due_results.pop_front();
      if (got.latch !== exp.latch) flag_mismatch("latch_out", exp.latch, got.latch);
      if (got.clock !== exp.clock) flag_mismatch("clock_out", exp.clock, got.clock);
      if (got.done !== exp.done) flag_mismatch("poll_done", exp.done, got.done);
      if (got.buttons !== exp.buttons) flag_mismatch("buttons", exp.buttons, got.buttons);
      if (got.keys !== exp.keys) flag_mismatch("keypad_keys", exp.keys, got.keys);
      if (got.present !== exp.present) flag_mismatch("keypad_present", exp.present, got.present);
      if (got.connected !== exp.connected) flag_mismatch("connected", exp.connected, got.connected);
      if (got.player !== exp.player) flag_mismatch("player", exp.player, got.player);
      if (got.busy !== exp.busy) flag_mismatch("busy_res", exp.busy, got.busy);
      if (got.pad !== exp.pad) flag_mismatch("tdata padding", exp.pad, got.pad);
    endfunction
  endclass

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int N_SETTINGS    = 12;
  localparam int RANDOM_TICKS  = 22;
  localparam int HOLD_CYCLES   = 40;
  localparam logic [2:0] REG_UNUSED_LO = REG_PLAYER + 3'd1;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [0] start_poll, [1] data_line, [2] keypad_line
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [0] latch, [1] clock, [2] done, [18:3] buttons,
                               // [34:19] keys, [35] present, [36] connected,
                               // [39:37] player, [40] busy
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  poll_shadow  shadow = new();
  int          cycles = 0;
  int          send_idle_pct = 9;
  int          recv_idle_pct = 45;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  logic [15:0] btn_lines = '1;   // line level per button position, 0 = pressed
  logic [15:0] key_lines = '1;   // line level per keypad position

  gamepad_serial_poller #(
    .BUTTON_BITS(poll_shadow::N_BUTTONS),
    .TOTAL_BITS (poll_shadow::N_TOTAL),
    .DETECT_BIT (poll_shadow::DETECT_POS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check accepted words, watch the cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end else if (!rst && m_tvalid && m_tready) begin
      shadow.match_result(m_tdata);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one tick word and wait for it to be taken; called at a falling edge
  task automatic send_word(input logic [7:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    shadow.take_tick(w);
    @(negedge clk);
  endtask

  // Lines follow the poll pattern at the position about to be sampled
  function automatic logic [7:0] line_word(bit start, int noise_pct);
    int pos;
    bit d, k;
    pos = shadow.next_sample_pos();
    d = (pos < 16) ? btn_lines[pos] : 1'($urandom_range(1));
    k = (pos >= 16 && pos < 32) ? key_lines[pos-16] : 1'($urandom_range(1));
    if ($urandom_range(99) < noise_pct) begin
      d = 1'($urandom_range(1));
      k = 1'($urandom_range(1));
    end
    return {5'd0, k, d, start};
  endfunction

  function automatic void pick_patterns();
    btn_lines = 16'($urandom);
    key_lines = 16'($urandom);
    case ($urandom_range(5))
      0: btn_lines[poll_shadow::DETECT_POS] = 1'b0;   // keypad attached
      1: btn_lines[poll_shadow::DETECT_POS] = 1'b1;   // plain pad
      2: begin
        btn_lines = '1;
        key_lines = '1;
      end
      3: begin
        btn_lines = '0;
        key_lines = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic reg_write(input int idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(input int idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 5'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== shadow.read_reg(idx))
      shadow.flag_mismatch($sformatf("register %0d readback", idx), shadow.read_reg(idx), prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all();
    reg_read(REG_LATCH_HIGH);
    reg_read(REG_LATCH_LOW);
    reg_read(REG_CLOCK_HIGH);
    reg_read(REG_CLOCK_LOW);
    reg_read(REG_PLAYER);
  endtask

  task automatic set_timing(input logic [31:0] lh, ll, ch, cl);
    reg_write(REG_LATCH_HIGH, lh);
    reg_write(REG_LATCH_LOW, ll);
    reg_write(REG_CLOCK_HIGH, ch);
    reg_write(REG_CLOCK_LOW, cl);
  endtask

  // Stop sending and wait until every due result word has left the block
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (shadow.due_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Finish any poll in flight, then run one complete poll on fixed lines
  task automatic run_poll(input logic [15:0] btn, input logic [15:0] key, input bit busy_req);
    while (!shadow.idle()) send_word(line_word(1'b0, 0));
    btn_lines = btn;
    key_lines = key;
    send_word(line_word(1'b1, 0));
    while (!shadow.idle()) send_word(line_word(busy_req, 0));
  endtask

  task automatic run_random_ticks(input int n);
    bit st;
    for (int i = 0; i < n; i++) begin
      if (shadow.idle()) begin
        st = ($urandom_range(99) < 60);
        if (st) pick_patterns();
      end else begin
        // requests while busy must be ignored
        st = ($urandom_range(99) < 15);
      end
      send_word(line_word(st, 8));
    end
  endtask

  // Mostly one-tick phases so many polls complete; upper bits of pwdata are junk
  function automatic logic [7:0] short_len();
    if ($urandom_range(99) < 85) return 8'($urandom_range(1));
    return 8'($urandom_range(4, 12));
  endfunction

  task automatic random_setting();
    set_timing({24'($urandom), short_len()}, {24'($urandom), short_len()},
               {24'($urandom), short_len()}, {24'($urandom), short_len()});
    reg_write(REG_PLAYER, {29'($urandom), 3'($urandom_range(7))});
    if ($urandom_range(99) < 30)
      reg_write($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI), $urandom);
    read_all();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    read_all();

    // Idle ticks, no request, every line combination
    send_word({5'd0, 1'b0, 1'b0, 1'b0});
    send_word({5'd0, 1'b0, 1'b1, 1'b0});
    send_word({5'd0, 1'b1, 1'b0, 1'b0});
    send_word({5'd0, 1'b1, 1'b1, 1'b0});
    drain_results();

    // Zero lengths behave as one; everything pressed, requests held while busy
    set_timing(32'd0, 32'd0, 32'd0, 32'd0);
    reg_write(REG_PLAYER, {29'd0, PLAYER_MAX});
    read_all();
    run_poll(16'h0000, 16'h0000, 1'b1);
    // nothing pressed, no keypad
    run_poll(16'hFFFF, 16'hFFFF, 1'b0);
    drain_results();

    // Single-tick phases, junk in the upper data bits
    set_timing(32'hA5A5_5A01, 32'hFFFF_FF01, 32'h1234_5601, 32'h8000_0001);
    reg_write(REG_PLAYER, {29'h1FFF_FFFF, PLAYER_MIN});
    // rejected player numbers and writes to unused addresses
    reg_write(REG_PLAYER, 32'd0);
    reg_write(REG_PLAYER, 32'd5);
    reg_write(REG_PLAYER, 32'd7);
    for (int a = REG_UNUSED_LO; a <= REG_UNUSED_HI; a++) reg_write(a, 32'hFFFF_FFFF);
    read_all();
    // only the detect button pressed: keypad read, skipped position included
    run_poll(~(16'd1 << poll_shadow::DETECT_POS), 16'h0000, 1'b0);
    run_poll(16'h0000, 16'h5555, 1'b1);
    run_poll(16'h5AA5, 16'hAAAA, 1'b0);

    // Random polls; registers change between phases, often mid-poll
    for (int s = 0; s < N_SETTINGS; s++) begin
      if (s == N_SETTINGS / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 9;
      end
      if (s == 2 * N_SETTINGS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_results();
      random_setting();
      // long receiver hold-off while the sender keeps pushing
      if (s == N_SETTINGS - 3) hold_request = 1'b1;
      run_random_ticks(RANDOM_TICKS);
    end

    // Longest latch-high phase, keypad attached
    while (!shadow.idle()) send_word(line_word(1'b0, 8));
    drain_results();
    set_timing(32'd255, 32'd1, 32'd1, 32'd1);
    reg_write(REG_PLAYER, {29'd0, PLAYER_MAX});
    read_all();
    pick_patterns();
    run_poll(btn_lines & ~(16'd1 << poll_shadow::DETECT_POS), key_lines, 1'b1);

    drain_results();
    repeat (4) @(posedge clk);
    $display("Sent %0d tick words, checked %0d result words, %0d register accesses written",
             shadow.words_in, shadow.words_out, shadow.settings);
    $display("Completed %0d polls, %0d of them with the keypad extension",
             shadow.polls_done, shadow.keypad_polls);
    if (shadow.errors == 0 && shadow.due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d result words missing",
               shadow.errors, shadow.due_results.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
